// ----- design/aabbx_pkg.sv -----
package aabbx_pkg;

  localparam int FIELD_W = 32;
  localparam int AXIS_W = 2;
  localparam int LANES = 3;
  localparam int MAG_W = FIELD_W + 1;
  localparam int PROD_W = MAG_W + FIELD_W;
  localparam int ACC_W = PROD_W + 1;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_BITS_DEF = 32;

  localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

  // raw item as taken from the input channel
  typedef struct packed {
    logic [AXIS_W-1:0]               axis;
    logic                            last;
    logic [FIELD_W-1:0]              shift;
    logic [LANES-1:0][FIELD_W-1:0]   row;
    logic [LANES-1:0][FIELD_W-1:0]   bmin;
    logic [LANES-1:0][FIELD_W-1:0]   bmax;
  } raw_t;

  // local center, half extent and row magnitude per lane
  typedef struct packed {
    logic [AXIS_W-1:0]               axis;
    logic                            last;
    logic [FIELD_W-1:0]              shift;
    logic [LANES-1:0][FIELD_W-1:0]   row;
    logic [LANES-1:0][FIELD_W-1:0]   cen;
    logic [LANES-1:0][FIELD_W-1:0]   half;
    logic [LANES-1:0][FIELD_W-1:0]   mag;
  } prep_t;

  typedef struct packed {
    logic [AXIS_W-1:0]               axis;
    logic                            last;
    logic [FIELD_W-1:0]              shift;
    logic [LANES-1:0][PROD_W-1:0]    cprod;
    logic [LANES-1:0][PROD_W-1:0]    eprod;
  } prod_t;

  typedef struct packed {
    logic [AXIS_W-1:0]               axis;
    logic                            last;
    logic [ACC_W-1:0]                center;
    logic [ACC_W-1:0]                extent;
  } sum_t;

  typedef struct packed {
    logic [AXIS_W-1:0]               axis;
    logic                            last;
    logic [FIELD_W-1:0]              lo;
    logic [FIELD_W-1:0]              hi;
  } node_t;

  function automatic int sat_bits(input int coord_bits);
    return (coord_bits < FIELD_W) ? coord_bits : FIELD_W;
  endfunction

endpackage

// ----- design/aabbx_in_if.sv -----
interface aabbx_in_if;
  logic                                valid;
  logic                                ready;
  logic [aabbx_pkg::AXIS_W-1:0]        axis;
  logic signed [aabbx_pkg::FIELD_W-1:0] row_x;
  logic signed [aabbx_pkg::FIELD_W-1:0] row_y;
  logic signed [aabbx_pkg::FIELD_W-1:0] row_z;
  logic signed [aabbx_pkg::FIELD_W-1:0] row_shift;
  logic signed [aabbx_pkg::FIELD_W-1:0] box_min_x;
  logic signed [aabbx_pkg::FIELD_W-1:0] box_min_y;
  logic signed [aabbx_pkg::FIELD_W-1:0] box_min_z;
  logic signed [aabbx_pkg::FIELD_W-1:0] box_max_x;
  logic signed [aabbx_pkg::FIELD_W-1:0] box_max_y;
  logic signed [aabbx_pkg::FIELD_W-1:0] box_max_z;
  logic                                last_node;

  modport source (
    output valid, axis, row_x, row_y, row_z, row_shift,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, last_node,
    input  ready
  );

  modport sink (
    input  valid, axis, row_x, row_y, row_z, row_shift,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, last_node,
    output ready
  );
endinterface

interface aabbx_out_if;
  logic                                valid;
  logic                                ready;
  logic [aabbx_pkg::AXIS_W-1:0]        out_axis;
  logic signed [aabbx_pkg::FIELD_W-1:0] node_lo;
  logic signed [aabbx_pkg::FIELD_W-1:0] node_hi;
  logic signed [aabbx_pkg::FIELD_W-1:0] union_lo;
  logic signed [aabbx_pkg::FIELD_W-1:0] union_hi;
  logic                                union_done;

  modport source (
    output valid, out_axis, node_lo, node_hi, union_lo, union_hi, union_done,
    input  ready
  );

  modport sink (
    input  valid, out_axis, node_lo, node_hi, union_lo, union_hi, union_done,
    output ready
  );
endinterface

// ----- design/aabbx_front.sv -----
module aabbx_front (
  input  logic                 clk,
  input  logic                 rst,
  aabbx_in_if.sink             item,
  output logic                 prep_valid,
  input  logic                 prep_ready,
  output aabbx_pkg::prep_t     prep
);

  logic              raw_valid;
  aabbx_pkg::raw_t   raw;
  aabbx_pkg::prep_t  prep_next;
  logic              prep_free;

  assign prep_free = !prep_valid || prep_ready;
  assign item.ready = !raw_valid || prep_free;

  // items on the unused axis are taken but leave no trace
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_valid <= 1'b0;
    end else if (item.ready) begin
      raw_valid <= item.valid && (item.axis != aabbx_pkg::AXIS_NONE);
    end
    if (item.ready && item.valid) begin
      raw.axis    <= item.axis;
      raw.last    <= item.last_node;
      raw.shift   <= item.row_shift;
      raw.row[0]  <= item.row_x;
      raw.row[1]  <= item.row_y;
      raw.row[2]  <= item.row_z;
      raw.bmin[0] <= item.box_min_x;
      raw.bmin[1] <= item.box_min_y;
      raw.bmin[2] <= item.box_min_z;
      raw.bmax[0] <= item.box_max_x;
      raw.bmax[1] <= item.box_max_y;
      raw.bmax[2] <= item.box_max_z;
    end
  end

  always_comb begin
    logic [aabbx_pkg::FIELD_W:0] sum;
    logic [aabbx_pkg::FIELD_W:0] dif;
    prep_next.axis  = raw.axis;
    prep_next.last  = raw.last;
    prep_next.shift = raw.shift;
    prep_next.row   = raw.row;
    for (int j = 0; j < aabbx_pkg::LANES; j++) begin
      sum = {raw.bmin[j][aabbx_pkg::FIELD_W-1], raw.bmin[j]}
          + {raw.bmax[j][aabbx_pkg::FIELD_W-1], raw.bmax[j]};
      dif = {raw.bmax[j][aabbx_pkg::FIELD_W-1], raw.bmax[j]}
          - {raw.bmin[j][aabbx_pkg::FIELD_W-1], raw.bmin[j]};
      // dropping the low bit is a floor halving
      prep_next.cen[j]  = sum[aabbx_pkg::FIELD_W:1];
      prep_next.half[j] = dif[aabbx_pkg::FIELD_W:1];
      prep_next.mag[j]  = raw.row[j][aabbx_pkg::FIELD_W-1] ? (~raw.row[j] + 1'b1)
                                                           : raw.row[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else if (prep_free) begin
      prep_valid <= raw_valid;
    end
    if (prep_free && raw_valid) begin
      prep <= prep_next;
    end
  end

endmodule

// ----- design/aabbx_mul.sv -----
module aabbx_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 prep_valid,
  output logic                 prep_ready,
  input  aabbx_pkg::prep_t     prep,
  output logic                 prod_valid,
  input  logic                 prod_ready,
  output aabbx_pkg::prod_t     prod
);

  aabbx_pkg::prod_t prod_next;

  assign prep_ready = !prod_valid || prod_ready;

  always_comb begin
    logic signed [aabbx_pkg::MAG_W-1:0]  mag_s;
    logic signed [aabbx_pkg::PROD_W-1:0] cp;
    logic signed [aabbx_pkg::PROD_W-1:0] ep;
    prod_next.axis  = prep.axis;
    prod_next.last  = prep.last;
    prod_next.shift = prep.shift;
    for (int j = 0; j < aabbx_pkg::LANES; j++) begin
      mag_s = $signed({1'b0, prep.mag[j]});
      cp = aabbx_pkg::PROD_W'($signed(prep.row[j])) * aabbx_pkg::PROD_W'($signed(prep.cen[j]));
      ep = aabbx_pkg::PROD_W'(mag_s) * aabbx_pkg::PROD_W'($signed(prep.half[j]));
      prod_next.cprod[j] = cp;
      prod_next.eprod[j] = ep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prep_ready) begin
      prod_valid <= prep_valid;
    end
    if (prep_ready && prep_valid) begin
      prod <= prod_next;
    end
  end

endmodule

// ----- design/aabbx_bound.sv -----
module aabbx_bound #(
  parameter int FRAC_BITS  = aabbx_pkg::FRAC_BITS_DEF,
  parameter int COORD_BITS = aabbx_pkg::COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 prod_valid,
  output logic                 prod_ready,
  input  aabbx_pkg::prod_t     prod,
  output logic                 node_valid,
  input  logic                 node_ready,
  output aabbx_pkg::node_t     node
);

  localparam int ACC_W = aabbx_pkg::ACC_W;
  localparam int SAT_BITS = aabbx_pkg::sat_bits(COORD_BITS);
  localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = (ACC_W'(1) << (SAT_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  logic              sum_valid;
  logic              sum_free;
  aabbx_pkg::sum_t   sum;
  aabbx_pkg::sum_t   sum_next;
  aabbx_pkg::node_t  node_next;

  assign sum_free   = !node_valid || node_ready;
  assign prod_ready = !sum_valid || sum_free;

  function automatic logic signed [ACC_W-1:0] fx_round(
    input logic [aabbx_pkg::PROD_W-1:0] p
  );
    logic signed [ACC_W-1:0] t;
    t = $signed({p[aabbx_pkg::PROD_W-1], p}) + ROUND;
    return t >>> FRAC_BITS;
  endfunction

  function automatic logic [aabbx_pkg::FIELD_W-1:0] clamp(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] c;
    if (v > SAT_MAX) begin
      c = SAT_MAX;
    end else if (v < SAT_MIN) begin
      c = SAT_MIN;
    end else begin
      c = v;
    end
    return c[aabbx_pkg::FIELD_W-1:0];
  endfunction

  always_comb begin
    logic signed [ACC_W-1:0] cacc;
    logic signed [ACC_W-1:0] eacc;
    cacc = ACC_W'($signed(prod.shift));
    eacc = '0;
    for (int j = 0; j < aabbx_pkg::LANES; j++) begin
      cacc = cacc + fx_round(prod.cprod[j]);
      eacc = eacc + fx_round(prod.eprod[j]);
    end
    sum_next.axis   = prod.axis;
    sum_next.last   = prod.last;
    sum_next.center = cacc;
    sum_next.extent = eacc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (prod_ready) begin
      sum_valid <= prod_valid;
    end
    if (prod_ready && prod_valid) begin
      sum <= sum_next;
    end
  end

  always_comb begin
    node_next.axis = sum.axis;
    node_next.last = sum.last;
    node_next.lo   = clamp($signed(sum.center) - $signed(sum.extent));
    node_next.hi   = clamp($signed(sum.center) + $signed(sum.extent));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_valid <= 1'b0;
    end else if (sum_free) begin
      node_valid <= sum_valid;
    end
    if (sum_free && sum_valid) begin
      node <= node_next;
    end
  end

endmodule

// ----- design/aabbx_union.sv -----
module aabbx_union #(
  parameter int COORD_BITS = aabbx_pkg::COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 node_valid,
  output logic                 node_ready,
  input  aabbx_pkg::node_t     node,
  aabbx_out_if.source          result
);

  localparam int FW = aabbx_pkg::FIELD_W;
  localparam int SAT_BITS = aabbx_pkg::sat_bits(COORD_BITS);
  localparam logic signed [FW-1:0] SAT_MAX = (FW'(1) << (SAT_BITS - 1)) - FW'(1);
  localparam logic signed [FW-1:0] SAT_MIN = -SAT_MAX - FW'(1);

  logic signed [FW-1:0] run_lo [aabbx_pkg::LANES];
  logic signed [FW-1:0] run_hi [aabbx_pkg::LANES];
  logic signed [FW-1:0] uni_lo;
  logic signed [FW-1:0] uni_hi;

  assign node_ready = !result.valid || result.ready;

  always_comb begin
    uni_lo = ($signed(node.lo) < run_lo[node.axis]) ? $signed(node.lo) : run_lo[node.axis];
    uni_hi = ($signed(node.hi) > run_hi[node.axis]) ? $signed(node.hi) : run_hi[node.axis];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      for (int a = 0; a < aabbx_pkg::LANES; a++) begin
        run_lo[a] <= SAT_MAX;
        run_hi[a] <= SAT_MIN;
      end
    end else begin
      if (node_ready) begin
        result.valid <= node_valid;
      end
      if (node_ready && node_valid) begin
        // the closing node is reported in the union, then the axis starts over
        run_lo[node.axis] <= node.last ? SAT_MAX : uni_lo;
        run_hi[node.axis] <= node.last ? SAT_MIN : uni_hi;
      end
    end
    if (node_ready && node_valid) begin
      result.out_axis   <= node.axis;
      result.node_lo    <= node.lo;
      result.node_hi    <= node.hi;
      result.union_lo   <= uni_lo;
      result.union_hi   <= uni_hi;
      result.union_done <= node.last;
    end
  end

endmodule

// ----- design/affine_aabb_transform_union.sv -----
// Affine box transform with per-axis running union.
// item channel: one matrix row (row_x, row_y, row_z, row_shift), the local box
// corners, the world axis and last_node. result channel: the node's world
// interval on that axis plus the running union over nodes of that axis.
// An item on axis three is taken and dropped, producing no result.
// The datapath is a six-register pipeline: input register, center and half
// extent, six parallel multiplies, rounding sums, clamp, union update with
// the result register. One item is taken every cycle while results are
// drained. The union is read and written in the last stage only, so
// back-to-back nodes of the same axis see each other's contribution.
// Each stage holds its data while the next one is full, so a stalled
// receiver fills the pipeline and then drops item.ready; nothing is lost.
// Synchronous reset empties the pipeline and sets every axis union to empty
// (low at the largest value, high at the smallest).
module affine_aabb_transform_union #(
  parameter int FRAC_BITS  = aabbx_pkg::FRAC_BITS_DEF,
  parameter int COORD_BITS = aabbx_pkg::COORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  aabbx_in_if.sink     item,
  aabbx_out_if.source  result
);

  logic              prep_valid;
  logic              prep_ready;
  aabbx_pkg::prep_t  prep;
  logic              prod_valid;
  logic              prod_ready;
  aabbx_pkg::prod_t  prod;
  logic              node_valid;
  logic              node_ready;
  aabbx_pkg::node_t  node;

  aabbx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .prep_valid (prep_valid),
    .prep_ready (prep_ready),
    .prep       (prep)
  );

  aabbx_mul u_mul (
    .clk        (clk),
    .rst        (rst),
    .prep_valid (prep_valid),
    .prep_ready (prep_ready),
    .prep       (prep),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod)
  );

  aabbx_bound #(
    .FRAC_BITS  (FRAC_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_bound (
    .clk        (clk),
    .rst        (rst),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod),
    .node_valid (node_valid),
    .node_ready (node_ready),
    .node       (node)
  );

  aabbx_union #(
    .COORD_BITS (COORD_BITS)
  ) u_union (
    .clk        (clk),
    .rst        (rst),
    .node_valid (node_valid),
    .node_ready (node_ready),
    .node       (node),
    .result     (result)
  );

endmodule

// ----- test/affine_aabb_transform_union_test.sv -----
module affine_aabb_transform_union_test;

  localparam int FIELD_W = aabbx_pkg::FIELD_W;
  localparam int AXIS_W = aabbx_pkg::AXIS_W;
  localparam logic [AXIS_W-1:0] AXIS_NONE = aabbx_pkg::AXIS_NONE;
  localparam int FRAC = aabbx_pkg::FRAC_BITS_DEF;
  localparam int SAT_W = (aabbx_pkg::COORD_BITS_DEF < FIELD_W) ? aabbx_pkg::COORD_BITS_DEF
                                                                : FIELD_W;
  localparam longint SAT_MAX = (longint'(1) <<< (SAT_W - 1)) - 1;
  localparam longint SAT_MIN = -SAT_MAX - 1;
  localparam logic signed [FIELD_W-1:0] ONE = 32'sh0001_0000;
  localparam logic signed [FIELD_W-1:0] HALF = 32'sh0000_8000;
  localparam logic signed [FIELD_W-1:0] WMAX = 32'sh7fff_ffff;
  localparam logic signed [FIELD_W-1:0] WMIN = 32'sh8000_0000;
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;
  localparam int RANDOM_NODES = 1550;
  localparam int LONG_HOLD = 150;
  localparam int SETTLE = 20;
  localparam int TIME_LIMIT = 2_000_000;

  typedef enum int {VAL_SCENE, VAL_RAW, VAL_CORNER} val_kind_t;

  typedef struct packed {
    logic [AXIS_W-1:0]         axis;
    logic signed [FIELD_W-1:0] row_x;
    logic signed [FIELD_W-1:0] row_y;
    logic signed [FIELD_W-1:0] row_z;
    logic signed [FIELD_W-1:0] row_shift;
    logic signed [FIELD_W-1:0] min_x;
    logic signed [FIELD_W-1:0] min_y;
    logic signed [FIELD_W-1:0] min_z;
    logic signed [FIELD_W-1:0] max_x;
    logic signed [FIELD_W-1:0] max_y;
    logic signed [FIELD_W-1:0] max_z;
    logic                      last;
    logic                      drain_first;
  } box_item_t;

  typedef struct packed {
    logic [AXIS_W-1:0]         axis;
    logic signed [FIELD_W-1:0] node_lo;
    logic signed [FIELD_W-1:0] node_hi;
    logic signed [FIELD_W-1:0] union_lo;
    logic signed [FIELD_W-1:0] union_hi;
    logic                      done;
  } world_span_t;

  logic clk;
  logic rst;

  aabbx_in_if  node_in ();
  aabbx_out_if node_out ();

  affine_aabb_transform_union i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (node_in),
    .result (node_out)
  );

  box_item_t   stim_q [$];
  world_span_t expected_spans [$];
  longint      span_lo [3];
  longint      span_hi [3];
  box_item_t   sent;
  world_span_t want;
  logic        offering;
  logic        taking;
  logic        held_long;
  int          send_gap;
  int          send_burst;
  int          recv_gap;
  int          recv_burst;
  int          hold_left;
  int          spans_seen;
  int          mismatches;

  function automatic void add_stim(box_item_t n);
    stim_q = {stim_q, n};
  endfunction

  function automatic void add_span(world_span_t w);
    expected_spans = {expected_spans, w};
  endfunction

  function automatic longint round_q(longint p);
    return (p + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic longint saturate(longint v);
    if (v > SAT_MAX) return SAT_MAX;
    if (v < SAT_MIN) return SAT_MIN;
    return v;
  endfunction

  // world interval of one node on its axis, folded into the running union
  function automatic world_span_t transform_node(box_item_t n);
    longint row [3];
    longint bmin [3];
    longint bmax [3];
    longint center;
    longint extent;
    longint c;
    longint h;
    longint mag;
    longint lo;
    longint hi;
    world_span_t w;
    row[0] = longint'(n.row_x);
    row[1] = longint'(n.row_y);
    row[2] = longint'(n.row_z);
    bmin[0] = longint'(n.min_x);
    bmin[1] = longint'(n.min_y);
    bmin[2] = longint'(n.min_z);
    bmax[0] = longint'(n.max_x);
    bmax[1] = longint'(n.max_y);
    bmax[2] = longint'(n.max_z);
    center = longint'(n.row_shift);
    extent = 0;
    for (int j = 0; j < 3; j++) begin
      c = (bmin[j] + bmax[j]) >>> 1;
      h = (bmax[j] - bmin[j]) >>> 1;
      mag = (row[j] < 0) ? -row[j] : row[j];
      center += round_q(row[j] * c);
      extent += round_q(mag * h);
    end
    lo = saturate(center - extent);
    hi = saturate(center + extent);
    if (lo < span_lo[n.axis]) span_lo[n.axis] = lo;
    if (hi > span_hi[n.axis]) span_hi[n.axis] = hi;
    w.axis = n.axis;
    w.node_lo = lo[FIELD_W-1:0];
    w.node_hi = hi[FIELD_W-1:0];
    w.union_lo = span_lo[n.axis][FIELD_W-1:0];
    w.union_hi = span_hi[n.axis][FIELD_W-1:0];
    w.done = n.last;
    if (n.last) begin
      span_lo[n.axis] = SAT_MAX;
      span_hi[n.axis] = SAT_MIN;
    end
    return w;
  endfunction

  function automatic box_item_t box_item(
    logic [AXIS_W-1:0] ax,
    logic signed [FIELD_W-1:0] rx, logic signed [FIELD_W-1:0] ry,
    logic signed [FIELD_W-1:0] rz, logic signed [FIELD_W-1:0] sh,
    logic signed [FIELD_W-1:0] nx, logic signed [FIELD_W-1:0] ny,
    logic signed [FIELD_W-1:0] nz, logic signed [FIELD_W-1:0] px,
    logic signed [FIELD_W-1:0] py, logic signed [FIELD_W-1:0] pz,
    logic last
  );
    box_item_t n;
    n.axis = ax;
    n.row_x = rx;
    n.row_y = ry;
    n.row_z = rz;
    n.row_shift = sh;
    n.min_x = nx;
    n.min_y = ny;
    n.min_z = nz;
    n.max_x = px;
    n.max_y = py;
    n.max_z = pz;
    n.last = last;
    n.drain_first = 1'b0;
    return n;
  endfunction

  function automatic logic signed [FIELD_W-1:0] corner_word();
    case ($urandom_range(0, 6))
      0: return WMIN;
      1: return WMAX;
      2: return '0;
      3: return 32'sd1;
      4: return -32'sd1;
      5: return ONE;
      default: return -ONE;
    endcase
  endfunction

  function automatic box_item_t random_node(logic [AXIS_W-1:0] ax, logic last,
                                            val_kind_t kind);
    logic signed [FIELD_W-1:0] r [3];
    logic signed [FIELD_W-1:0] mn [3];
    logic signed [FIELD_W-1:0] mx [3];
    logic signed [FIELD_W-1:0] sh;
    logic signed [FIELD_W-1:0] ctr;
    logic signed [FIELD_W-1:0] ext;
    for (int j = 0; j < 3; j++) begin
      case (kind)
        VAL_RAW: begin
          r[j] = $urandom;
          mn[j] = $urandom;
          mx[j] = $urandom;
        end
        VAL_CORNER: begin
          r[j] = corner_word();
          mn[j] = corner_word();
          mx[j] = corner_word();
        end
        default: begin
          // rows within +-4.0, boxes within about +-768.0
          r[j] = int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
          ctr = int'($urandom_range(0, 32'h400_0000)) - 32'sh200_0000;
          ext = int'($urandom_range(0, 32'h100_0000));
          if ($urandom_range(0, 19) == 0) ext = -ext;
          mn[j] = ctr - ext;
          mx[j] = ctr + ext;
        end
      endcase
    end
    case (kind)
      VAL_RAW: sh = $urandom;
      VAL_CORNER: sh = corner_word();
      default: sh = int'($urandom_range(0, 32'h800_0000)) - 32'sh400_0000;
    endcase
    return box_item(ax, r[0], r[1], r[2], sh, mn[0], mn[1], mn[2],
                    mx[0], mx[1], mx[2], last);
  endfunction

  function automatic int idle_len();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  task automatic check_field(string what, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, what, exp_v, act_v);
      mismatches++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(TIME_LIMIT);
    $display("status: fail");
    $finish;
  end

  // driver: one item offered at a time, held until the transfer
  always @(posedge clk) begin
    if (rst) begin
      node_in.valid <= 1'b0;
      offering = 1'b0;
    end else begin
      if (offering && node_in.ready) begin
        if (sent.axis != AXIS_NONE) add_span(transform_node(sent));
        offering = 1'b0;
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (stim_q.size() != 0 &&
                     !(stim_q[0].drain_first && expected_spans.size() != 0 &&
                       hold_left == 0)) begin
          sent = stim_q.pop_front();
          offering = 1'b1;
          node_in.axis <= sent.axis;
          node_in.row_x <= sent.row_x;
          node_in.row_y <= sent.row_y;
          node_in.row_z <= sent.row_z;
          node_in.row_shift <= sent.row_shift;
          node_in.box_min_x <= sent.min_x;
          node_in.box_min_y <= sent.min_y;
          node_in.box_min_z <= sent.min_z;
          node_in.box_max_x <= sent.max_x;
          node_in.box_max_y <= sent.max_y;
          node_in.box_max_z <= sent.max_z;
          node_in.last_node <= sent.last;
          if (send_burst > 0) begin
            send_burst--;
            send_gap = 0;
          end else begin
            send_gap = idle_len();
            if ($urandom_range(0, 39) == 0) send_burst = int'($urandom_range(30, 150));
          end
        end
      end
      node_in.valid <= offering;
    end
  end

  // long back-pressure so the pipeline fills and drops item ready
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      held_long <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!held_long && spans_seen >= 400) begin
      held_long <= 1'b1;
      hold_left <= LONG_HOLD;
    end
  end

  // monitor: checks each transfer against the oldest predicted span
  always @(posedge clk) begin
    if (rst) begin
      node_out.ready <= 1'b0;
      taking = 1'b0;
    end else begin
      if (taking && node_out.valid) begin
        spans_seen++;
        if (expected_spans.size() == 0) begin
          $display("%0t unexpected result: expected none actual axis %0d lo %0d hi %0d",
                   $time, node_out.out_axis, node_out.node_lo, node_out.node_hi);
          mismatches++;
        end else begin
          want = expected_spans.pop_front();
          check_field("out_axis", longint'(want.axis), longint'(node_out.out_axis));
          check_field("node_lo", longint'(want.node_lo), longint'(node_out.node_lo));
          check_field("node_hi", longint'(want.node_hi), longint'(node_out.node_hi));
          check_field("union_lo", longint'(want.union_lo), longint'(node_out.union_lo));
          check_field("union_hi", longint'(want.union_hi), longint'(node_out.union_hi));
          check_field("union_done", longint'(want.done), longint'(node_out.union_done));
        end
      end
      if (hold_left > 0) begin
        taking = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        taking = 1'b0;
      end else begin
        taking = 1'b1;
        if (recv_burst > 0) begin
          recv_burst--;
          recv_gap = 0;
        end else begin
          recv_gap = idle_len();
          if ($urandom_range(0, 39) == 0) recv_burst = int'($urandom_range(30, 150));
        end
      end
      node_out.ready <= taking;
    end
  end

  initial begin
    box_item_t  n;
    val_kind_t  kind;
    int         issued;
    int         pick;
    int         nodes;
    logic       pause;
    logic       first_mesh;

    rst = 1'b1;
    node_in.valid = 1'b0;
    node_in.axis = '0;
    node_in.row_x = '0;
    node_in.row_y = '0;
    node_in.row_z = '0;
    node_in.row_shift = '0;
    node_in.box_min_x = '0;
    node_in.box_min_y = '0;
    node_in.box_min_z = '0;
    node_in.box_max_x = '0;
    node_in.box_max_y = '0;
    node_in.box_max_z = '0;
    node_in.last_node = 1'b0;
    node_out.ready = 1'b0;
    offering = 1'b0;
    taking = 1'b0;
    send_gap = 0;
    send_burst = 0;
    recv_gap = 0;
    recv_burst = 0;
    spans_seen = 0;
    mismatches = 0;
    for (int i = 0; i < 3; i++) begin
      span_lo[i] = SAT_MAX;
      span_hi[i] = SAT_MIN;
    end

    // directed items
    add_stim(box_item(AXIS_X, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    add_stim(box_item(AXIS_X, ONE, 0, 0, 5 * ONE, -ONE, -2 * ONE, -3 * ONE,
                      ONE, 2 * ONE, 3 * ONE, 1'b0));
    add_stim(box_item(AXIS_X, -ONE, HALF, 2 * ONE, -ONE, -4 * ONE, ONE, -ONE,
                      -2 * ONE, 3 * ONE, 7 * ONE, 1'b1));
    // union right after a clear holds only this node
    add_stim(box_item(AXIS_X, ONE, 0, 0, 0, 0, 0, 0, HALF, 0, 0, 1'b1));
    // saturation at both ends
    add_stim(box_item(AXIS_Y, WMIN, WMIN, WMIN, WMAX, WMIN, WMIN, WMIN,
                      WMAX, WMAX, WMAX, 1'b0));
    add_stim(box_item(AXIS_Y, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX,
                      WMAX, WMAX, WMAX, 1'b0));
    add_stim(box_item(AXIS_Y, WMAX, WMIN, WMAX, WMIN, WMIN, WMAX, WMIN,
                      WMAX, WMIN, WMAX, 1'b1));
    // inverted box: negative half extent, node_lo above node_hi
    add_stim(box_item(AXIS_Z, ONE, ONE, ONE, 0, 3 * ONE, 0, 0,
                      -3 * ONE, 0, 0, 1'b0));
    // axis three is dropped without a result
    add_stim(box_item(AXIS_NONE, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 1'b1));
    // rounding of products at exactly one half
    add_stim(box_item(AXIS_Z, 32'sd1, -32'sd1, 32'sd1, 0, HALF, HALF, HALF - 1,
                      HALF, HALF, HALF - 1, 1'b0));
    add_stim(box_item(AXIS_Z, -32'sd1, -32'sd1, -32'sd1, 0, HALF + 1, HALF,
                      -HALF, HALF + 1, HALF, -HALF, 1'b1));
    // odd corner sums round down when halved
    add_stim(box_item(AXIS_X, ONE, ONE, ONE, 0, 0, -1, -3, 1, 0, 0, 1'b0));
    add_stim(box_item(AXIS_X, 0, 0, 0, WMAX, 0, 0, 0, 0, 0, 0, 1'b0));
    add_stim(box_item(AXIS_X, 0, 0, 0, WMIN, 0, 0, 0, 0, 0, 0, 1'b1));
    add_stim(box_item(AXIS_Y, -ONE, -ONE, -ONE, ONE, WMIN, WMIN, WMIN,
                      WMIN, WMIN, WMIN, 1'b1));
    add_stim(box_item(AXIS_Z, WMIN, 0, WMAX, -ONE, WMAX, WMIN, 0,
                      WMIN, WMAX, -1, 1'b1));

    // random meshes: every node sends its three axis rows, the last node closes
    issued = 0;
    first_mesh = 1'b1;
    while (issued < RANDOM_NODES) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 8) kind = VAL_RAW;
      else if (pick < 12) kind = VAL_CORNER;
      else kind = VAL_SCENE;
      pick = int'($urandom_range(0, 99));
      if (pick < 4) begin
        add_stim(random_node(AXIS_NONE, 1'($urandom_range(0, 1)), VAL_RAW));
      end else if (pick < 14) begin
        add_stim(random_node(AXIS_W'($urandom_range(0, 2)),
                             1'($urandom_range(0, 1)), kind));
        issued++;
      end else begin
        nodes = int'($urandom_range(1, 6));
        pause = first_mesh || ($urandom_range(0, 39) == 0);
        first_mesh = 1'b0;
        for (int k = 0; k < nodes; k++) begin
          for (int a = 0; a < 3; a++) begin
            n = random_node(AXIS_W'(a), k == nodes - 1, kind);
            n.drain_first = pause && k == 0 && a == 0;
            add_stim(n);
            issued++;
          end
        end
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || offering) @(posedge clk);
    while (expected_spans.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
